>>> design/madr_pkg.sv
//------------------------------------------------------------------------------
// madr_pkg
// Shared constants and state types for the moving average deviation ratio unit.
//------------------------------------------------------------------------------
`default_nettype none

package madr_pkg;

	localparam int MAX_WINDOW_DEF = 256;
	localparam int PRICE_BITS_DEF = 32;

	localparam int WLEN_W = 9;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd3;

	localparam int RATIO_W   = 32;
	localparam int FRAC_BITS = 24;
	localparam int QUO_W     = RATIO_W - 1;
	localparam int INT_BITS  = QUO_W - FRAC_BITS;
	localparam int CNT_W     = $clog2(QUO_W + 1);

	localparam logic [RATIO_W-1:0] RATIO_MAX = {1'b0, {(RATIO_W-1){1'b1}}};
	localparam logic [RATIO_W-1:0] RATIO_MIN = {1'b1, {(RATIO_W-1){1'b0}}};

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		FR_IDLE,
		FR_UPD
	} front_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_SUB,
		BK_CHK,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

`default_nettype wire

>>> design/madr_front.sv
//------------------------------------------------------------------------------
// madr_front
// Window keeper: delay line, running sum, fill tracking and job issue.
//------------------------------------------------------------------------------
`default_nettype none

module madr_front #(
	parameter int MAX_WINDOW = madr_pkg::MAX_WINDOW_DEF,
	parameter int PRICE_BITS = madr_pkg::PRICE_BITS_DEF,
	localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW),
	localparam int WCNT_W = $clog2(MAX_WINDOW + 1),
	localparam int JOB_W  = SUM_W + PRICE_BITS + WCNT_W + 2
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [madr_pkg::WLEN_W-1:0]   cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [PRICE_BITS-1:0]         sample,
	input  wire logic [PRICE_BITS-1:0]         open_price,
	input  wire logic                          last_of_series,
	input  wire logic                          q_space,
	output logic                               job_push,
	output logic [JOB_W-1:0]                   job_data
);
	import madr_pkg::*;

	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int CMP_W = (WCNT_W > WLEN_W) ? WCNT_W : WLEN_W;

	front_state_t state_q, state_d;

	logic [WLEN_W-1:0]     win_len_q;
	logic [SUM_W-1:0]      sum_q;
	logic [WCNT_W-1:0]     fill_q;
	logic [IDX_W-1:0]      wp_q;
	logic                  halted_q;

	logic [PRICE_BITS-1:0] sample_s1;
	logic [PRICE_BITS-1:0] open_s1;
	logic                  last_s1;
	logic [IDX_W-1:0]      wp_s1;
	logic [PRICE_BITS-1:0] old_q;

	logic [PRICE_BITS-1:0] hist_mem [MAX_WINDOW];

	logic [CMP_W-1:0]  wlen_ext;
	logic [WCNT_W-1:0] win;
	logic [IDX_W-1:0]  wp_eff;
	logic              accept;
	logic              mem_re;
	logic              upd_en;
	logic              full_now;
	logic [SUM_W-1:0]  sum_base;
	logic [SUM_W-1:0]  sum_new;
	logic [WCNT_W-1:0] fill_new;
	logic [WCNT_W-1:0] wp_inc;
	logic [IDX_W-1:0]  wp_new;
	logic              gives;
	logic              sum_zero;

	// clamp the programmed length into 1..MAX_WINDOW
	always_comb begin
		wlen_ext = CMP_W'(win_len_q);
		if (wlen_ext == '0) begin
			win = WCNT_W'(1);
		end else if (wlen_ext > CMP_W'(MAX_WINDOW)) begin
			win = WCNT_W'(MAX_WINDOW);
		end else begin
			win = wlen_ext[WCNT_W-1:0];
		end
	end

	assign wp_eff = (WCNT_W'(wp_q) >= win) ? '0 : wp_q;
	assign accept = in_valid && in_ready;

	always_comb begin
		full_now = (fill_q >= win);
		sum_base = full_now ? (sum_q - SUM_W'(old_q)) : sum_q;
		sum_new  = sum_base + SUM_W'(sample_s1);
		fill_new = full_now ? fill_q : (fill_q + WCNT_W'(1));
		wp_inc   = WCNT_W'(wp_s1) + WCNT_W'(1);
		wp_new   = (wp_inc >= win) ? '0 : wp_inc[IDX_W-1:0];
		gives    = (fill_new >= win);
		sum_zero = (sum_new == '0);
	end

	assign job_data = {last_s1, sum_zero, win, open_s1, sum_new};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: begin
				if (accept && !halted_q) begin
					state_d = FR_UPD;
				end
			end
			FR_UPD: begin
				state_d = FR_IDLE;
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		mem_re   = 1'b0;
		upd_en   = 1'b0;
		job_push = 1'b0;
		case (state_q)
			FR_IDLE: begin
				in_ready = halted_q || q_space;
				mem_re   = accept && !halted_q;
			end
			FR_UPD: begin
				upd_en   = 1'b1;
				job_push = gives;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// delay line: read the outgoing sample on accept, overwrite it in the following cycle
	always_ff @(posedge clk) begin
		if (upd_en) begin
			hist_mem[wp_s1] <= sample_s1;
		end
		if (mem_re) begin
			old_q <= hist_mem[wp_eff];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			sample_s1 <= sample;
			open_s1   <= open_price;
			last_s1   <= last_of_series;
			wp_s1     <= wp_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FR_IDLE;
			win_len_q <= WLEN_RESET;
			sum_q     <= '0;
			fill_q    <= '0;
			wp_q      <= '0;
			halted_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upd_en) begin
				if (last_s1) begin
					sum_q  <= '0;
					fill_q <= '0;
					wp_q   <= '0;
				end else begin
					sum_q  <= sum_new;
					fill_q <= fill_new;
					wp_q   <= wp_new;
				end
				if (gives && sum_zero) begin
					halted_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				win_len_q <= cfg_wdata;
				sum_q     <= '0;
				fill_q    <= '0;
				wp_q      <= '0;
			end
		end
	end

`ifndef ASSERT_OFF
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag dropped without reset");

	a_no_job_halted: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !halted_q)
		else $error("job issued while halted");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win)
		else $error("fill count beyond window length");
`endif

endmodule

`default_nettype wire

>>> design/madr_queue.sv
//------------------------------------------------------------------------------
// madr_queue
// Short job queue between the window keeper and the divider.
//------------------------------------------------------------------------------
`default_nettype none

module madr_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  space,
	input  wire logic             pop,
	output logic                  pop_valid,
	output logic [WIDTH-1:0]      pop_data
);
	import madr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]  slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign space     = (count_q != CNT_QW'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_QW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_QW'(1);
			end
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CNT_QW'(QUEUE_DEPTH)) || pop)
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue underflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_QW'(QUEUE_DEPTH))
		else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

>>> design/madr_back.sv
//------------------------------------------------------------------------------
// madr_back
// Ratio engine: scale the open price, form the deviation, divide, saturate.
//------------------------------------------------------------------------------
`default_nettype none

module madr_back #(
	parameter int MAX_WINDOW = madr_pkg::MAX_WINDOW_DEF,
	parameter int PRICE_BITS = madr_pkg::PRICE_BITS_DEF,
	localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW),
	localparam int WCNT_W = $clog2(MAX_WINDOW + 1),
	localparam int JOB_W  = SUM_W + PRICE_BITS + WCNT_W + 2
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           job_valid,
	input  wire logic [JOB_W-1:0]               job_data,
	output logic                                job_pop,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [madr_pkg::RATIO_W-1:0]        m_tdata,
	output logic                                m_tuser,
	output logic                                m_tlast
);
	import madr_pkg::*;

	localparam int PROD_W = WCNT_W + PRICE_BITS;

	back_state_t state_q, state_d;

	logic [SUM_W-1:0]      den_q;
	logic [PRICE_BITS-1:0] open_q;
	logic [WCNT_W-1:0]     win_q;
	logic                  err_q;
	logic                  last_q;
	logic [SUM_W-1:0]      scaled_q;
	logic [SUM_W-1:0]      mag_q;
	logic                  neg_q;
	logic                  sat_q;
	logic [SUM_W:0]        rem_q;
	logic [QUO_W-1:0]      bits_q;
	logic [QUO_W-1:0]      quo_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  m_tvalid_q;
	logic [RATIO_W-1:0]    m_tdata_q;
	logic                  m_tuser_q;
	logic                  m_tlast_q;

	logic [PROD_W-1:0]     prod;
	logic                  sat;
	logic [SUM_W:0]        trial;
	logic                  trial_ge;
	logic                  out_free;
	logic                  load_out;
	logic [RATIO_W-1:0]    quo_ext;
	logic [RATIO_W-1:0]    ratio;

	assign prod     = PROD_W'(win_q) * PROD_W'(open_q);
	assign sat      = ({{INT_BITS{1'b0}}, mag_q} >= {den_q, {INT_BITS{1'b0}}});
	assign trial    = {rem_q[SUM_W-1:0], bits_q[QUO_W-1]};
	assign trial_ge = (trial >= {1'b0, den_q});
	assign out_free = !m_tvalid_q || m_tready;
	assign quo_ext  = {1'b0, quo_q};

	always_comb begin
		if (err_q) begin
			ratio = '0;
		end else if (sat_q) begin
			ratio = neg_q ? RATIO_MIN : RATIO_MAX;
		end else begin
			ratio = neg_q ? (RATIO_W'(0) - quo_ext) : quo_ext;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					state_d = job_data[SUM_W+PRICE_BITS+WCNT_W] ? BK_DONE : BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_SUB;
			end
			BK_SUB: begin
				state_d = BK_CHK;
			end
			BK_CHK: begin
				state_d = sat ? BK_DONE : BK_DIV;
			end
			BK_DIV: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		job_pop  = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				job_pop = job_valid;
			end
			BK_DONE: begin
				load_out = out_free;
			end
			default: begin
				job_pop = 1'b0;
			end
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					den_q  <= job_data[SUM_W-1:0];
					open_q <= job_data[SUM_W +: PRICE_BITS];
					win_q  <= job_data[SUM_W+PRICE_BITS +: WCNT_W];
					err_q  <= job_data[SUM_W+PRICE_BITS+WCNT_W];
					last_q <= job_data[SUM_W+PRICE_BITS+WCNT_W+1];
				end
			end
			BK_MUL: begin
				scaled_q <= prod[SUM_W-1:0];
			end
			BK_SUB: begin
				neg_q <= (den_q < scaled_q);
				mag_q <= (den_q < scaled_q) ? (scaled_q - den_q) : (den_q - scaled_q);
			end
			BK_CHK: begin
				sat_q  <= sat;
				rem_q  <= (SUM_W+1)'(mag_q >> INT_BITS);
				bits_q <= {mag_q[INT_BITS-1:0], {FRAC_BITS{1'b0}}};
				quo_q  <= '0;
				cnt_q  <= CNT_W'(QUO_W);
			end
			BK_DIV: begin
				rem_q  <= trial_ge ? (trial - {1'b0, den_q}) : trial;
				quo_q  <= {quo_q[QUO_W-2:0], trial_ge};
				bits_q <= {bits_q[QUO_W-2:0], 1'b0};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= ratio;
			m_tuser_q <= err_q;
			m_tlast_q <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef ASSERT_OFF
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (rem_q < {1'b0, den_q}))
		else $error("partial remainder not below divisor");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (den_q != '0))
		else $error("divide started on zero window sum");

	a_err_ratio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("error result with nonzero ratio");
`endif

endmodule

`default_nettype wire

>>> design/moving_average_deviation_ratio_unit.sv
//------------------------------------------------------------------------------
// moving_average_deviation_ratio_unit
// Moving window average of a price stream and its relative deviation
// (avg - open) / avg as signed fixed point with 24 fraction bits.
//------------------------------------------------------------------------------
// Channel   Dir  Handshake          Content
// s_*       in   tvalid / tready    sample, open_price in tdata; last_of_series on tlast
// m_*       out  tvalid / tready    ratio in tdata; zero_sum_error on tuser;
//                                   end_of_series on tlast
// cfg_*     in   cfg_we             window_length, written with no wait
//
// Each item passes the window keeper as a delay line read, then a sum update
// and write back; the keeper takes no new transfer in between. Jobs then go
// to the ratio engine, whose radix-2 restoring divider produces one quotient
// bit per cycle and sets the sustained result rate. A two-entry job queue lets
// the keeper take new transfers while the engine divides, and the result
// register lets the engine start the next job while a result waits on
// m_tready. After reset the block is ready at once; a zero window sum returns
// an error result and then every input transfer is taken and dropped until
// reset.
//------------------------------------------------------------------------------
`default_nettype none

module moving_average_deviation_ratio_unit #(
	parameter int MAX_WINDOW = madr_pkg::MAX_WINDOW_DEF,
	parameter int PRICE_BITS = madr_pkg::PRICE_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// window_length
	input  wire logic                                  cfg_we,
	input  wire logic [madr_pkg::WLEN_W-1:0]           cfg_wdata,
	// input stream
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	// tdata: sample, open_price (lowest bits first), zero padded to bytes
	input  wire logic [((2*PRICE_BITS+7)/8)*8-1:0]     s_tdata,
	input  wire logic                                  s_tlast,
	// result stream
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	// tdata: ratio
	output logic [madr_pkg::RATIO_W-1:0]               m_tdata,
	// tuser: zero_sum_error
	output logic                                       m_tuser,
	output logic                                       m_tlast
);
	import madr_pkg::*;

	localparam int SUM_W  = PRICE_BITS + $clog2(MAX_WINDOW);
	localparam int WCNT_W = $clog2(MAX_WINDOW + 1);
	localparam int JOB_W  = SUM_W + PRICE_BITS + WCNT_W + 2;

	// job path between the keeper and the engine
	logic             push;
	logic [JOB_W-1:0] push_data;
	logic             q_space;
	logic             pop;
	logic             pop_valid;
	logic [JOB_W-1:0] pop_data;

	// front: hold the window, classify each transfer into drop, fill or job
	madr_front #(
		.MAX_WINDOW (MAX_WINDOW),
		.PRICE_BITS (PRICE_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.sample         (s_tdata[PRICE_BITS-1:0]),
		.open_price     (s_tdata[2*PRICE_BITS-1:PRICE_BITS]),
		.last_of_series (s_tlast),
		.q_space        (q_space),
		.job_push       (push),
		.job_data       (push_data)
	);

	// queue: decouple window updates from the long divide
	madr_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.space     (q_space),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	// back: scale, subtract, divide, saturate and present the result
	madr_back #(
		.MAX_WINDOW (MAX_WINDOW),
		.PRICE_BITS (PRICE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_data  (pop_data),
		.job_pop   (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

>>> tb/tb_moving_average_deviation_ratio_unit.sv
//------------------------------------------------------------------------------
// tb_moving_average_deviation_ratio_unit
// Self-checking bench for the moving average deviation ratio unit. It streams
// price bars over several window lengths and predicts every ratio in the bench.
// Each output transfer is compared field by field with the oldest prediction.
//------------------------------------------------------------------------------

module tb_moving_average_deviation_ratio_unit;

	// Longest quiet stretch of a correct run: the output hold plus one job, or
	// the pause before a register write. Allow it several times over.
	localparam int STALL_LIMIT = 4000;
	// Idle cycles before a register write, or at the end. This covers an item
	// that only fills the window and may still sit in the window keeper.
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES = 600;
	localparam int NUM_PHASES = 12;

	typedef struct {
		logic [madr_pkg::RATIO_W-1:0] ratio;
		logic zero_sum;
		logic eos;
	} deviation_t;

	// Window predictor plus the queue of ratios still owed by the block
	class ratio_scoreboard;
		logic [31:0] win_hist [madr_pkg::MAX_WINDOW_DEF];
		bit [39:0] wsum;
		int fill;
		int wptr;
		bit halted;
		logic [madr_pkg::WLEN_W-1:0] wlen;
		deviation_t due [$];
		int accepted;
		int checked;
		int mismatches;

		function new();
			foreach (win_hist[i])
				win_hist[i] = '0;
			wlen = madr_pkg::WLEN_RESET;
			halted = 1'b0;
			clear_window();
		endfunction

		function void clear_window();
			wsum = '0;
			fill = 0;
			wptr = 0;
		endfunction

		function int eff_window();
			if (wlen == 0)
				return 1;
			if (wlen > madr_pkg::MAX_WINDOW_DEF)
				return madr_pkg::MAX_WINDOW_DEF;
			return int'(wlen);
		endfunction

		function void set_window(logic [madr_pkg::WLEN_W-1:0] v);
			wlen = v;
			clear_window();
		endfunction

		// True when this sample would complete a window whose sum is zero
		function bit would_zero(logic [31:0] smp);
			int w;
			int p;
			bit [39:0] nsum;
			if (halted)
				return 1'b0;
			w = eff_window();
			p = (wptr >= w) ? 0 : wptr;
			nsum = wsum + smp - ((fill >= w) ? win_hist[p] : 32'd0);
			return (fill + 1 >= w) && (nsum == 0);
		endfunction

		function void note_sample(logic [31:0] smp, logic [31:0] opn, logic last);
			int w;
			bit [63:0] scaled;
			bit [63:0] mag;
			bit [63:0] quo;
			deviation_t d;
			accepted++;
			if (halted)
				return;
			w = eff_window();
			if (wptr >= w)
				wptr = 0;
			if (fill >= w)
				wsum -= win_hist[wptr];
			else
				fill++;
			win_hist[wptr] = smp;
			wsum += smp;
			wptr = (wptr + 1 >= w) ? 0 : wptr + 1;
			if (fill >= w) begin
				d.ratio = '0;
				d.zero_sum = 1'b0;
				d.eos = last;
				scaled = 64'(w) * 64'(opn);
				if (wsum == 0) begin
					d.zero_sum = 1'b1;
					halted = 1'b1;
				end else if (64'(wsum) >= scaled) begin
					mag = 64'(wsum) - scaled;
					quo = (mag << madr_pkg::FRAC_BITS) / 64'(wsum);
					if (quo > 64'(madr_pkg::RATIO_MAX))
						quo = 64'(madr_pkg::RATIO_MAX);
					d.ratio = quo[31:0];
				end else begin
					mag = scaled - 64'(wsum);
					quo = (mag << madr_pkg::FRAC_BITS) / 64'(wsum);
					if (quo > 64'(madr_pkg::RATIO_MIN))
						quo = 64'(madr_pkg::RATIO_MIN);
					d.ratio = 32'(64'd0 - quo);
				end
				due.push_back(d);
			end
			if (last)
				clear_window();
		endfunction

		function void report(string what, logic [31:0] got, logic [31:0] want);
			mismatches++;
			$display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
		endfunction

		function void check_ratio(logic [31:0] r, logic e, logic l);
			deviation_t d;
			checked++;
			if (due.size() == 0) begin
				report("unexpected result", r, '0);
				return;
			end
			d = due.pop_front();
			if (r !== d.ratio)
				report("ratio", r, d.ratio);
			if (e !== d.zero_sum)
				report("zero_sum_error", 32'(e), 32'(d.zero_sum));
			if (l !== d.eos)
				report("end_of_series", 32'(l), 32'(d.eos));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [madr_pkg::WLEN_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;	// sample [31:0], open_price [63:32]
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [madr_pkg::RATIO_W-1:0] m_tdata;	// ratio [31:0]
	logic m_tuser;	// zero_sum_error [0]
	logic m_tlast;

	ratio_scoreboard sb = new();

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_cycles = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	int settings_used = 0;

	moving_average_deviation_ratio_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// Check every output transfer; end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_ratio(m_tdata, m_tuser, m_tlast);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold while the sender keeps going
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				hold_cycles--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Offer one bar and hold it until the transfer; idle first at random.
	// Rotate the idling pattern every 40 bars so gaps hit every stage of a job.
	task automatic offer_bar(logic [31:0] smp, logic [31:0] opn, logic last);
		case ((items_sent / 40) % 4)
			0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
			2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
			default: begin sender_idle_pct = 19; recv_stall_pct = 19; end
		endcase
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {opn, smp};
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_sample(smp, opn, last);
		items_sent++;
	endtask

	// Wait for every owed result, then let any filling item leave the block
	task automatic drain_results();
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_window(logic [madr_pkg::WLEN_W-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_window(v);
		settings_used++;
	endtask

	initial begin
		int plan_window [NUM_PHASES];
		int plan_items [NUM_PHASES];
		int left;
		int len;
		int w;
		int style;
		logic [31:0] base;
		logic [31:0] smp;
		logic [31:0] opn;

		// Extremes 1 and 256, the out-of-range codes 0 and 511, and common lengths
		plan_window = '{1, 2, 8, 21, 55, 144, 256, 5, 0, 511, 34, 3};
		plan_items = '{110, 110, 120, 110, 120, 150, 280, 100, 90, 270, 110, 110};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bars at the reset window length of 3
		settings_used = 1;
		offer_bar(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);	// fill, no result
		offer_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);	// fill, no result
		offer_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);	// largest sum, ratio zero
		offer_bar(32'h0000_0001, 32'h0000_0000, 1'b0);	// open zero: ratio one
		offer_bar(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);	// large negative
		offer_bar(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);	// saturates low
		offer_bar(32'h0000_0000, 32'h0000_0001, 1'b0);	// zero sample, sum nonzero
		offer_bar(32'h0001_0000, 32'h0000_AAAA, 1'b1);	// result that ends a series
		offer_bar(32'h0000_5555, 32'h0000_5555, 1'b1);	// series ends while filling
		offer_bar(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		offer_bar(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		offer_bar(32'h0123_4567, 32'h89AB_CDEF, 1'b0);
		offer_bar(32'h8000_0000, 32'h8000_0000, 1'b1);
		s_tvalid <= 1'b0;

		// Random series; a phase may stop mid-series so the write clears a live window
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			load_window(madr_pkg::WLEN_W'(plan_window[ph]));
			left = plan_items[ph];
			while (left > 0) begin
				w = sb.eff_window();
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(1, w);
				else
					len = w - 1 + $urandom_range(1, 40);
				if (len > left)
					len = left;
				style = $urandom_range(0, 4);
				base = $urandom();
				for (int k = 0; k < len; k++) begin
					case (style)
						0: begin
							smp = $urandom();
							opn = $urandom();
						end
						1: begin
							// prices close to each other: small ratios
							smp = base + $urandom_range(0, 4095) - 32'd2048;
							opn = base + $urandom_range(0, 4095) - 32'd2048;
						end
						2: begin
							smp = $urandom();
							opn = $urandom_range(0, 1) ? 32'd0 : $urandom();
						end
						3: begin
							// tiny sums against large opens: saturation
							smp = $urandom_range(0, 255);
							opn = $urandom() | 32'h8000_0000;
						end
						default: begin
							smp = $urandom() >> $urandom_range(0, 31);
							opn = $urandom() >> $urandom_range(0, 31);
						end
					endcase
					// keep the zero-sum halt for the very end of the run
					if (sb.would_zero(smp))
						smp = 32'd1;
					// hold the result side long enough to back up the input
					if (ph == 2 && left == plan_items[ph] - 20)
						hold_cycles = HOLD_CYCLES;
					offer_bar(smp, opn, (k == len - 1) && (len < left || k < len - 1) ?
						1'b1 : (k == len - 1 && len == left && $urandom_range(0, 1)));
					left--;
				end
			end
			s_tvalid <= 1'b0;
		end

		// Zero window sum: one error result, then the block drops everything
		load_window(madr_pkg::WLEN_W'(2));
		offer_bar(32'h0000_0000, 32'h0000_1234, 1'b0);
		offer_bar(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		offer_bar(32'h0000_0001, 32'h0000_0001, 1'b0);
		offer_bar(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		offer_bar(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		offer_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		s_tvalid <= 1'b0;
		drain_results();

		$display("Run covered %0d input transfers and %0d checked results",
			sb.accepted, sb.checked);
		$display("over %0d window settings, with saturation, series ends,", settings_used);
		$display("mid-series writes, a long hold and the zero-sum halt.");
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
